// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/dbrm_pkg.sv -----
package dbrm_pkg;

    // Field widths.
    localparam int PTR_W = 6;
    localparam int CNT_W = 32;
    localparam int OP_W = 3;
    localparam int STS_W = 2;

    // Histogram geometry: one bin per possible ring occupancy.
    localparam int HIST_DEPTH = 64;
    localparam int HIST_AW = $clog2(HIST_DEPTH);

    // Reset value of the last buffer index register.
    localparam logic [PTR_W-1:0] LAST_IDX_RESET = PTR_W'(HIST_DEPTH - 1);

    // Remainder unit: one quotient bit per step over a pointer.
    localparam int MOD_STEPS = PTR_W;
    localparam int MOD_STEP_W = $clog2(MOD_STEPS);
    localparam logic [MOD_STEP_W-1:0] MOD_LAST = MOD_STEP_W'(MOD_STEPS - 1);

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_START   = 3'd0,
        OP_STOP    = 3'd1,
        OP_DONE    = 3'd2,
        OP_HWERR   = 3'd3,
        OP_CONSUME = 3'd4,
        OP_QUERY   = 3'd5
    } t_op;

    // Result status codes.
    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_BUSY  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    // Capture run state.
    typedef enum logic [1:0] {
        RUN_IDLE     = 2'd0,
        RUN_ACTIVE   = 2'd1,
        RUN_STOPPING = 2'd2
    } t_run;

    // Controller states.
    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_MOD  = 2'd1,
        CS_READ = 2'd2,
        CS_EXEC = 2'd3
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mod_step;
        logic hist_rd;
        logic exec;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_ring;
    } t_dp_sts;

endpackage

// ----- design/dma_buffer_ring_manager.sv -----
// Ring manager for DMA buffers shared by a capture card and a reader. An event is taken
// at a rising edge with start high and busy low; its single result is shown for exactly
// one cycle with o_valid high and cannot be held off, so the receiver must take it then.
// Start, stop, hardware error, consume and unused codes go from idle straight to the
// execute state; histogram query and buffer done first pass a read state, as the bin is
// read from a memory with a registered read port (buffer done then increments it). A
// buffer done with a pointer still beyond a ring that was shortened first passes both
// pointers through a six-step remainder unit. The result appears in the cycle in which
// busy falls, and a new start is taken in that same cycle. The ring size register may be
// written only while busy is low and no result is pending.
module dma_buffer_ring_manager (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dbrm_pkg::OP_W-1:0]     i_operation,
    input  logic [dbrm_pkg::HIST_AW-1:0]  i_bin_index,
    input  logic                          i_cfg_we,
    input  logic [dbrm_pkg::PTR_W-1:0]    i_cfg_wdata,
    output logic                          o_valid,
    output logic [dbrm_pkg::STS_W-1:0]    o_status,
    output logic [dbrm_pkg::PTR_W-1:0]    o_buffer_index,
    output logic                          o_refill_mailbox,
    output logic                          o_stop_card,
    output logic                          o_overrun,
    output logic [dbrm_pkg::CNT_W-1:0]    o_transfer_count,
    output logic [dbrm_pkg::CNT_W-1:0]    o_error_count,
    output logic [dbrm_pkg::CNT_W-1:0]    o_overrun_count,
    output logic [dbrm_pkg::CNT_W-1:0]    o_bin_count
);

    dbrm_pkg::t_dp_cmd dp_cmd;
    dbrm_pkg::t_dp_sts dp_sts;

    // Sequencer for one event at a time.
    dbrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd),
        .o_busy      (busy)
    );

    // Pointers, counters, histogram and result registers.
    dbrm_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .i_operation      (i_operation),
        .i_bin_index      (i_bin_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_buffer_index   (o_buffer_index),
        .o_refill_mailbox (o_refill_mailbox),
        .o_stop_card      (o_stop_card),
        .o_overrun        (o_overrun),
        .o_transfer_count (o_transfer_count),
        .o_error_count    (o_error_count),
        .o_overrun_count  (o_overrun_count),
        .o_bin_count      (o_bin_count)
    );

endmodule

// ----- design/dbrm_datapath.sv -----
module dbrm_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dbrm_pkg::t_dp_cmd             i_cmd,
    output dbrm_pkg::t_dp_sts             o_sts,
    input  logic [dbrm_pkg::OP_W-1:0]     i_operation,
    input  logic [dbrm_pkg::HIST_AW-1:0]  i_bin_index,
    input  logic                          i_cfg_we,
    input  logic [dbrm_pkg::PTR_W-1:0]    i_cfg_wdata,
    output logic                          o_valid,
    output logic [dbrm_pkg::STS_W-1:0]    o_status,
    output logic [dbrm_pkg::PTR_W-1:0]    o_buffer_index,
    output logic                          o_refill_mailbox,
    output logic                          o_stop_card,
    output logic                          o_overrun,
    output logic [dbrm_pkg::CNT_W-1:0]    o_transfer_count,
    output logic [dbrm_pkg::CNT_W-1:0]    o_error_count,
    output logic [dbrm_pkg::CNT_W-1:0]    o_overrun_count,
    output logic [dbrm_pkg::CNT_W-1:0]    o_bin_count
);

    localparam int PW = dbrm_pkg::PTR_W;
    localparam int CW = dbrm_pkg::CNT_W;
    localparam int AW = dbrm_pkg::HIST_AW;

    // Architectural state.
    logic [PW-1:0]         r_last_idx;
    logic [PW-1:0]         r_wr, n_wr;
    logic [PW-1:0]         r_rd, n_rd;
    logic                  r_first, n_first;
    dbrm_pkg::t_run        r_run, n_run;
    logic [CW-1:0]         r_transfers, n_transfers;
    logic [CW-1:0]         r_errors, n_errors;
    logic [CW-1:0]         r_overruns, n_overruns;

    // Latched item.
    dbrm_pkg::t_op         r_op;
    logic [AW-1:0]         r_bin;

    // Remainder unit: shifted dividends and partial remainders.
    logic [PW-1:0]         r_wsh, r_rsh;
    logic [PW-1:0]         r_wrem, r_rrem;

    // Occupancy histogram memory with per-bin valid bits.
    logic [CW-1:0]         r_hist [dbrm_pkg::HIST_DEPTH];
    logic [dbrm_pkg::HIST_DEPTH-1:0] r_hist_vld;
    logic [CW-1:0]         r_hist_rdata;
    logic                  r_rdata_vld;
    logic [AW-1:0]         r_hist_addr;
    logic [AW-1:0]         hist_raddr;
    logic [CW-1:0]         hist_val;
    logic                  hist_we;

    // Ring size and occupancy distance.
    logic [PW:0]           ring_size;
    logic [PW:0]           dist_sum;
    logic [PW:0]           occ_dist;

    // Result registers.
    logic                  r_valid;
    dbrm_pkg::t_status     r_status, n_status;
    logic [PW-1:0]         r_bidx, n_bidx;
    logic                  r_refill, n_refill;
    logic                  r_stop, n_stop;
    logic                  r_ovr, n_ovr;
    logic [CW-1:0]         r_bcount, n_bcount;

    // Pointer advance candidates.
    logic [PW-1:0]         wr_step, wr_adv, rd_step, rd_adv;

    // One restoring step of the remainder: shift in a dividend bit, subtract if it fits.
    function automatic logic [PW-1:0] rem_step(input logic [PW-1:0] rem,
                                               input logic          dbit,
                                               input logic [PW:0]   size);
        logic [PW:0] trial;
        trial = {rem, dbit};
        if (trial >= size) begin
            trial = trial - size;
        end
        return trial[PW-1:0];
    endfunction

    assign ring_size = {1'b0, r_last_idx} + (PW+1)'(1);

    // Both pointers already inside the ring need no remainder pass.
    assign o_sts.in_ring = (r_wr <= r_last_idx) && (r_rd <= r_last_idx);

    // True modular distance of the reduced pointers; it is always below the ring size.
    assign dist_sum = {1'b0, r_wrem} + ring_size - {1'b0, r_rrem};
    assign occ_dist = (dist_sum >= ring_size) ? (dist_sum - ring_size) : dist_sum;

    // The query reads its own bin, buffer done reads the occupancy bin.
    assign hist_raddr = (r_op == dbrm_pkg::OP_QUERY) ? r_bin : occ_dist[AW-1:0];
    assign hist_val   = r_rdata_vld ? r_hist_rdata : '0;

    // Pointer advance with wrap past the last buffer.
    assign wr_step = r_first ? r_wr : (r_wr + PW'(1));
    assign wr_adv  = (wr_step > r_last_idx) ? '0 : wr_step;
    assign rd_step = r_rd + PW'(1);
    assign rd_adv  = (rd_step > r_last_idx) ? '0 : rd_step;

    // Effect of the latched operation, applied in the execute cycle.
    always_comb begin
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_first     = r_first;
        n_run       = r_run;
        n_transfers = r_transfers;
        n_errors    = r_errors;
        n_overruns  = r_overruns;
        n_status    = dbrm_pkg::STS_OK;
        n_bidx      = '0;
        n_refill    = 1'b0;
        n_stop      = 1'b0;
        n_ovr       = 1'b0;
        n_bcount    = '0;
        hist_we     = 1'b0;
        if (i_cmd.exec) begin
            case (r_op)
                dbrm_pkg::OP_START: begin
                    if (r_run != dbrm_pkg::RUN_IDLE) begin
                        n_status = dbrm_pkg::STS_BUSY;
                    end else begin
                        n_run       = dbrm_pkg::RUN_ACTIVE;
                        n_first     = 1'b1;
                        n_rd        = r_wr;
                        n_transfers = '0;
                        n_errors    = '0;
                        n_overruns  = '0;
                        n_bidx      = r_wr;
                    end
                end
                dbrm_pkg::OP_STOP: begin
                    if (r_run == dbrm_pkg::RUN_ACTIVE) begin
                        n_run = dbrm_pkg::RUN_STOPPING;
                    end else begin
                        n_status = dbrm_pkg::STS_BUSY;
                    end
                end
                dbrm_pkg::OP_DONE: begin
                    n_refill = (r_run == dbrm_pkg::RUN_ACTIVE);
                    if (r_run == dbrm_pkg::RUN_STOPPING) begin
                        n_stop = 1'b1;
                        n_run  = dbrm_pkg::RUN_IDLE;
                    end
                    n_transfers = r_transfers + CW'(1);
                    hist_we     = 1'b1;
                    n_wr        = wr_adv;
                    if ((wr_adv == r_rd) && !r_first) begin
                        n_overruns = r_overruns + CW'(1);
                        n_ovr      = 1'b1;
                    end
                    n_first = 1'b0;
                    n_bidx  = wr_adv;
                end
                dbrm_pkg::OP_HWERR: begin
                    n_errors = r_errors + CW'(1);
                end
                dbrm_pkg::OP_CONSUME: begin
                    if (r_wr == r_rd) begin
                        n_status = dbrm_pkg::STS_EMPTY;
                    end else begin
                        n_bidx = r_rd;
                        n_rd   = rd_adv;
                    end
                end
                dbrm_pkg::OP_QUERY: begin
                    n_bcount = hist_val;
                end
                default: begin
                    n_status = dbrm_pkg::STS_BUSY;
                end
            endcase
        end
    end

    // Control state, counters, valid bits and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx  <= dbrm_pkg::LAST_IDX_RESET;
            r_wr        <= '0;
            r_rd        <= '0;
            r_first     <= 1'b1;
            r_run       <= dbrm_pkg::RUN_IDLE;
            r_transfers <= '0;
            r_errors    <= '0;
            r_overruns  <= '0;
            r_hist_vld  <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_last_idx <= i_cfg_wdata;
            end
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_first     <= n_first;
            r_run       <= n_run;
            r_transfers <= n_transfers;
            r_errors    <= n_errors;
            r_overruns  <= n_overruns;
            if (hist_we) begin
                r_hist_vld[r_hist_addr] <= 1'b1;
            end
            r_valid <= i_cmd.exec;
        end
    end

    // Item latch and remainder unit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= dbrm_pkg::t_op'(i_operation);
            r_bin  <= i_bin_index;
            r_wsh  <= r_wr;
            r_rsh  <= r_rd;
            r_wrem <= o_sts.in_ring ? r_wr : '0;
            r_rrem <= o_sts.in_ring ? r_rd : '0;
        end else if (i_cmd.mod_step) begin
            r_wsh  <= {r_wsh[PW-2:0], 1'b0};
            r_rsh  <= {r_rsh[PW-2:0], 1'b0};
            r_wrem <= rem_step(r_wrem, r_wsh[PW-1], ring_size);
            r_rrem <= rem_step(r_rrem, r_rsh[PW-1], ring_size);
        end
    end

    // Histogram memory: registered read, increment written back in the execute cycle.
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[r_hist_addr] <= hist_val + CW'(1);
        end
        if (i_cmd.hist_rd) begin
            r_hist_rdata <= r_hist[hist_raddr];
            r_rdata_vld  <= r_hist_vld[hist_raddr];
            r_hist_addr  <= hist_raddr;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_bidx   <= n_bidx;
            r_refill <= n_refill;
            r_stop   <= n_stop;
            r_ovr    <= n_ovr;
            r_bcount <= n_bcount;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_buffer_index   = r_bidx;
    assign o_refill_mailbox = r_refill;
    assign o_stop_card      = r_stop;
    assign o_overrun        = r_ovr;
    assign o_transfer_count = r_transfers;
    assign o_error_count    = r_errors;
    assign o_overrun_count  = r_overruns;
    assign o_bin_count      = r_bcount;

endmodule

// ----- design/dbrm_ctrl.sv -----
module dbrm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dbrm_pkg::OP_W-1:0]  i_operation,
    input  dbrm_pkg::t_dp_sts          i_sts,
    output dbrm_pkg::t_dp_cmd          o_cmd,
    output logic                       o_busy
);

    dbrm_pkg::t_ctrl_state r_state, n_state;
    logic [dbrm_pkg::MOD_STEP_W-1:0] r_step;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dbrm_pkg::CS_IDLE: begin
                if (i_start) begin
                    case (dbrm_pkg::t_op'(i_operation))
                        dbrm_pkg::OP_DONE: begin
                            n_state = i_sts.in_ring ? dbrm_pkg::CS_READ : dbrm_pkg::CS_MOD;
                        end
                        dbrm_pkg::OP_QUERY: begin
                            n_state = dbrm_pkg::CS_READ;
                        end
                        default: begin
                            n_state = dbrm_pkg::CS_EXEC;
                        end
                    endcase
                end
            end
            dbrm_pkg::CS_MOD: begin
                if (r_step == dbrm_pkg::MOD_LAST) begin
                    n_state = dbrm_pkg::CS_READ;
                end
            end
            dbrm_pkg::CS_READ: begin
                n_state = dbrm_pkg::CS_EXEC;
            end
            dbrm_pkg::CS_EXEC: begin
                n_state = dbrm_pkg::CS_IDLE;
            end
            default: begin
                n_state = dbrm_pkg::CS_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.load     = (r_state == dbrm_pkg::CS_IDLE) && i_start;
        o_cmd.mod_step = (r_state == dbrm_pkg::CS_MOD);
        o_cmd.hist_rd  = (r_state == dbrm_pkg::CS_READ);
        o_cmd.exec     = (r_state == dbrm_pkg::CS_EXEC);
        o_busy         = (r_state != dbrm_pkg::CS_IDLE);
    end

    // State register and remainder step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dbrm_pkg::CS_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == dbrm_pkg::CS_MOD) begin
                r_step <= r_step + dbrm_pkg::MOD_STEP_W'(1);
            end else begin
                r_step <= '0;
            end
        end
    end

endmodule

// ----- design/dbrm_checker.sv -----
`include "assert_macros.svh"

module dbrm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [dbrm_pkg::STS_W-1:0]  o_status,
    input logic                        o_refill_mailbox,
    input logic                        o_stop_card,
    input logic                        o_overrun
);

    logic accepted;
    logic flags_set;

    assign accepted  = start && !busy;
    assign flags_set = o_refill_mailbox || o_stop_card || o_overrun;

    // An accepted event keeps the block busy in the following cycle.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accepted, busy)

    // A result is shown only once the block has finished, right after a busy cycle.
    `ASSERT_SAME(a_valid_when_done, i_clk, i_rst_n, o_valid, !busy && $past(busy))

    // Each event yields one result strobe of a single cycle.
    `ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)

    // Buffer done is the only event that raises a flag, and it always succeeds.
    `ASSERT_SAME(a_flags_ok_status, i_clk, i_rst_n, o_valid && flags_set,
        o_status == dbrm_pkg::STS_OK)

endmodule

bind dma_buffer_ring_manager dbrm_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_refill_mailbox (o_refill_mailbox),
    .o_stop_card      (o_stop_card),
    .o_overrun        (o_overrun)
);
